>>> rtl/core/gjs_pkg.sv
// ----------------------------------------------------------------------------
// gjs_pkg
// Shared types and constants of the Gauss-Jordan solver: register indexes,
// fixed-point limits and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gjs_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned REG_W  = 4;
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned OUT_W  = 3;

    localparam logic [IDX_W-1:0] REG_SIZE_N    = 4'd0;
    localparam logic [IDX_W-1:0] REG_RHS_COUNT = 4'd1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // source of the word written into the work memory
    typedef enum logic [1:0] {
        WR_COPY,
        WR_UPDATE,
        WR_ZERO,
        WR_QUOT
    } t_wr_sel;

    typedef struct packed {
        logic    store_we;
        logic    work_we;
        t_wr_sel wr_sel;
        logic    lat_den;
        logic    lat_num;
        logic    num_from_b;
        logic    div_go;
        logic    mul_go;
        logic    lat_mul;
    } t_dp_cmd;

    typedef struct packed {
        logic den_zero;
        logic div_done;
    } t_dp_stat;

endpackage

>>> rtl/core/gjs_div.sv
// ----------------------------------------------------------------------------
// gjs_div
// Fixed-point divider: (num * 2^FRAC_BITS) / den, truncated toward zero and
// saturated to 32 bits. Restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gjs_div #(
    parameter int unsigned FRAC_BITS = 16,
    localparam int unsigned QW   = 32 + FRAC_BITS,
    localparam int unsigned CNTW = $clog2(QW + 1)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_go,
    input  logic signed [gjs_pkg::DATA_W-1:0]      i_num,
    input  logic signed [gjs_pkg::DATA_W-1:0]      i_den,
    output logic                                   o_done,
    output logic signed [gjs_pkg::DATA_W-1:0]      o_quot
);

    localparam logic [QW-1:0] HALF = {{(QW-32){1'b0}}, 32'h8000_0000};

    logic            r_run;
    logic            r_fin;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [QW-1:0]   r_dvd;
    logic [31:0]     r_rem;
    logic [31:0]     r_dmag;
    logic            r_neg;
    logic signed [31:0] r_quot;

    logic [31:0] w_nmag;
    logic [31:0] w_dmag;
    logic [32:0] w_trial;
    logic        w_ge;

    assign w_nmag  = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign w_dmag  = i_den[31] ? (~i_den + 32'd1) : i_den;
    assign w_trial = {r_rem, r_dvd[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_dvd  <= {w_nmag, {FRAC_BITS{1'b0}}};
                r_dmag <= w_dmag;
                r_neg  <= i_num[31] ^ i_den[31];
                r_rem  <= '0;
                r_cnt  <= CNTW'(QW);
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_rem <= w_ge ? 32'(w_trial - {1'b0, r_dmag}) : w_trial[31:0];
                r_dvd <= {r_dvd[QW-2:0], w_ge};
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                // saturate the magnitude and apply the sign
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                if (!r_neg) begin
                    r_quot <= (r_dvd >= HALF) ? gjs_pkg::SAT_MAX : $signed(r_dvd[31:0]);
                end else begin
                    r_quot <= (r_dvd > HALF) ? gjs_pkg::SAT_MIN
                                             : $signed(~r_dvd[31:0] + 32'd1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/core/gjs_dp.sv
// ----------------------------------------------------------------------------
// gjs_dp
// Solver datapath: element store, work memory with two read ports,
// multiply-accumulate with saturation and the shared divider.
// ----------------------------------------------------------------------------
module gjs_dp #(
    parameter int unsigned MAX_N     = 8,
    parameter int unsigned MAX_RHS   = 8,
    parameter int unsigned FRAC_BITS = 16,
    localparam int unsigned DEPTH = MAX_N * (MAX_N + MAX_RHS),
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gjs_pkg::t_dp_cmd                     i_cmd,
    output gjs_pkg::t_dp_stat                    o_stat,
    input  logic [AW-1:0]                        i_st_addr,
    input  logic signed [gjs_pkg::DATA_W-1:0]    i_load_value,
    input  logic [AW-1:0]                        i_wk_addr_a,
    input  logic [AW-1:0]                        i_wk_addr_b,
    input  logic [AW-1:0]                        i_wk_waddr,
    output logic signed [gjs_pkg::DATA_W-1:0]    o_rd_value
);

    logic signed [31:0] r_store [DEPTH];
    logic signed [31:0] r_work  [DEPTH];
    logic signed [31:0] r_st_q;
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;
    logic signed [31:0] r_den;
    logic signed [31:0] r_num;
    logic signed [31:0] r_mul;
    logic signed [31:0] r_x;
    logic signed [63:0] r_prod;

    logic signed [63:0] w_shift;
    logic signed [31:0] w_psat;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_usat;
    logic signed [31:0] w_wdata;
    logic signed [31:0] w_quot;
    logic               w_div_done;

    // element store, single port
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_we) begin
            r_store[i_st_addr] <= i_load_value;
        end
        r_st_q <= r_store[i_st_addr];
    end

    // work memory, one write and two reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.work_we) begin
            r_work[i_wk_waddr] <= w_wdata;
        end
        r_rd_a <= r_work[i_wk_addr_a];
        r_rd_b <= r_work[i_wk_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_den) begin
            r_den <= r_rd_a;
        end
        if (i_cmd.lat_num) begin
            r_num <= i_cmd.num_from_b ? r_rd_b : r_rd_a;
        end
        if (i_cmd.mul_go) begin
            r_prod <= 64'(r_mul) * 64'(r_rd_a);
            r_x    <= r_rd_b;
        end
        if (i_cmd.lat_mul) begin
            r_mul <= (w_quot == gjs_pkg::SAT_MIN) ? gjs_pkg::SAT_MAX : -w_quot;
        end
    end

    // floor shift, saturate, accumulate, saturate
    always_comb begin
        w_shift = r_prod >>> FRAC_BITS;
        if (w_shift > 64'(gjs_pkg::SAT_MAX)) begin
            w_psat = gjs_pkg::SAT_MAX;
        end else if (w_shift < 64'(gjs_pkg::SAT_MIN)) begin
            w_psat = gjs_pkg::SAT_MIN;
        end else begin
            w_psat = 32'(w_shift);
        end
        w_sum = 33'(r_x) + 33'(w_psat);
        if (w_sum > 33'(gjs_pkg::SAT_MAX)) begin
            w_usat = gjs_pkg::SAT_MAX;
        end else if (w_sum < 33'(gjs_pkg::SAT_MIN)) begin
            w_usat = gjs_pkg::SAT_MIN;
        end else begin
            w_usat = 32'(w_sum);
        end
    end

    always_comb begin
        case (i_cmd.wr_sel)
            gjs_pkg::WR_COPY:   w_wdata = r_st_q;
            gjs_pkg::WR_UPDATE: w_wdata = w_usat;
            gjs_pkg::WR_ZERO:   w_wdata = '0;
            gjs_pkg::WR_QUOT:   w_wdata = w_quot;
            default:            w_wdata = '0;
        endcase
    end

    gjs_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stat.den_zero = (r_den == '0);
    assign o_stat.div_done = w_div_done;
    assign o_rd_value      = r_rd_a;

endmodule

>>> rtl/core/gjs_ctrl.sv
// ----------------------------------------------------------------------------
// gjs_ctrl
// Solver controller: load count, copy sweep, forward and backward
// elimination, normalisation and result sequencing.
// ----------------------------------------------------------------------------
module gjs_ctrl #(
    parameter int unsigned MAX_N   = 8,
    parameter int unsigned MAX_RHS = 8,
    localparam int unsigned WMAX  = MAX_N + MAX_RHS,
    localparam int unsigned DEPTH = MAX_N * WMAX,
    localparam int unsigned AW    = $clog2(DEPTH),
    localparam int unsigned LW    = $clog2(DEPTH + 1),
    localparam int unsigned RW    = (MAX_N > 1) ? $clog2(MAX_N) : 1,
    localparam int unsigned CW    = $clog2(WMAX),
    localparam int unsigned NBW   = $clog2(MAX_N + 1),
    localparam int unsigned MBW   = $clog2(MAX_RHS + 1),
    localparam int unsigned WBW   = $clog2(WMAX + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_last,
    input  logic [NBW-1:0]     i_n,
    input  logic [MBW-1:0]     i_m,
    output logic               o_busy,
    output gjs_pkg::t_dp_cmd   o_cmd,
    input  gjs_pkg::t_dp_stat  i_stat,
    output logic [AW-1:0]      o_st_addr,
    output logic [AW-1:0]      o_wk_addr_a,
    output logic [AW-1:0]      o_wk_addr_b,
    output logic [AW-1:0]      o_wk_waddr,
    output logic               o_strobe,
    output logic [RW-1:0]      o_row,
    output logic [CW-1:0]      o_col,
    output logic               o_last,
    output logic               o_singular
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WR,
        S_PV_RD,
        S_PV_LAT,
        S_PV_CHK,
        S_RO_DIV,
        S_MA_RD,
        S_MA_MUL,
        S_MA_WR,
        S_NM_RD,
        S_NM_LAT,
        S_NM_CHK,
        S_ND_RD,
        S_ND_LAT,
        S_ND_GO,
        S_ND_WAIT,
        S_OUT_RD,
        S_OUT_EM
    } t_state;

    t_state          r_state;
    logic            r_busy;
    logic            r_fault;
    logic            r_back;
    logic            r_strobe;
    logic            r_last;
    logic [LW-1:0]   r_load;
    logic [AW-1:0]   r_k;
    logic [RW-1:0]   r_src;
    logic [RW-1:0]   r_dst;
    logic [CW-1:0]   r_p;
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   r_col;

    logic [WBW-1:0]  w_w;
    logic [LW-1:0]   w_total;
    logic [AW-1:0]   w_last_k;
    logic [RW-1:0]   w_last_row;
    logic [CW-1:0]   w_last_col;
    logic [CW-1:0]   w_last_rhs;

    function automatic logic [AW-1:0] f_addr(input logic [RW-1:0] row,
                                             input logic [CW-1:0] col);
        logic [AW-1:0] base;
        base = AW'(row) * AW'(w_w);
        return base + AW'(col);
    endfunction

    assign w_w        = WBW'(i_n) + WBW'(i_m);
    assign w_total    = LW'(LW'(i_n) * LW'(w_w));
    assign w_last_k   = AW'(w_total - LW'(1));
    assign w_last_row = RW'(i_n - NBW'(1));
    assign w_last_col = CW'(w_w - WBW'(1));
    assign w_last_rhs = CW'(i_m - MBW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_fault  <= 1'b0;
            r_back   <= 1'b0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_load   <= '0;
            r_k      <= '0;
            r_src    <= '0;
            r_dst    <= '0;
            r_p      <= '0;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (r_load < w_total) begin
                            r_load <= r_load + LW'(1);
                        end
                        if (i_last) begin
                            r_busy  <= 1'b1;
                            r_k     <= '0;
                            r_state <= S_COPY_RD;
                        end
                    end
                end
                S_COPY_RD: r_state <= S_COPY_WR;
                S_COPY_WR: begin
                    if (r_k == w_last_k) begin
                        r_p    <= '0;
                        r_src  <= '0;
                        r_back <= 1'b0;
                        if (w_last_row == '0) begin
                            r_state <= S_NM_RD;
                        end else begin
                            r_dst   <= RW'(1);
                            r_state <= S_PV_RD;
                        end
                    end else begin
                        r_k     <= r_k + AW'(1);
                        r_state <= S_COPY_RD;
                    end
                end
                S_PV_RD:  r_state <= S_PV_LAT;
                S_PV_LAT: r_state <= S_PV_CHK;
                S_PV_CHK: begin
                    if (i_stat.den_zero) begin
                        r_fault <= 1'b1;
                        r_src   <= '0;
                        r_p     <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_state <= S_RO_DIV;
                    end
                end
                S_RO_DIV: begin
                    if (i_stat.div_done) begin
                        r_p     <= '0;
                        r_state <= S_MA_RD;
                    end
                end
                S_MA_RD:  r_state <= S_MA_MUL;
                S_MA_MUL: r_state <= S_MA_WR;
                S_MA_WR: begin
                    if (r_p == w_last_col) begin
                        r_p     <= '0;
                        r_state <= S_PV_RD;
                        if (!r_back) begin
                            // forward sweep: rows below the pivot
                            if (r_dst == w_last_row) begin
                                if (r_src == w_last_row - RW'(1)) begin
                                    r_back <= 1'b1;
                                    r_src  <= w_last_row;
                                    r_dst  <= w_last_row - RW'(1);
                                end else begin
                                    r_src <= r_src + RW'(1);
                                    r_dst <= r_src + RW'(2);
                                end
                            end else begin
                                r_dst <= r_dst + RW'(1);
                            end
                        end else begin
                            // backward sweep: rows above the pivot
                            if (r_dst == '0) begin
                                if (r_src == RW'(1)) begin
                                    r_src   <= '0;
                                    r_state <= S_NM_RD;
                                end else begin
                                    r_src <= r_src - RW'(1);
                                    r_dst <= r_src - RW'(2);
                                end
                            end else begin
                                r_dst <= r_dst - RW'(1);
                            end
                        end
                    end else begin
                        r_p     <= r_p + CW'(1);
                        r_state <= S_MA_RD;
                    end
                end
                S_NM_RD:  r_state <= S_NM_LAT;
                S_NM_LAT: r_state <= S_NM_CHK;
                S_NM_CHK: begin
                    if (i_stat.den_zero) begin
                        r_fault <= 1'b1;
                        r_src   <= '0;
                        r_p     <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_p     <= '0;
                        r_state <= S_ND_RD;
                    end
                end
                S_ND_RD:  r_state <= S_ND_LAT;
                S_ND_LAT: r_state <= S_ND_GO;
                S_ND_GO:  r_state <= S_ND_WAIT;
                S_ND_WAIT: begin
                    if (i_stat.div_done) begin
                        if (r_p == w_last_col) begin
                            r_p <= '0;
                            if (r_src == w_last_row) begin
                                r_src   <= '0;
                                r_state <= S_OUT_RD;
                            end else begin
                                r_src   <= r_src + RW'(1);
                                r_state <= S_NM_RD;
                            end
                        end else begin
                            r_p     <= r_p + CW'(1);
                            r_state <= S_ND_RD;
                        end
                    end
                end
                // output walk: r_src is the row, r_p the right-hand-side column
                S_OUT_RD: begin
                    r_strobe <= 1'b1;
                    r_row    <= r_src;
                    r_col    <= r_p;
                    r_last   <= (r_src == w_last_row) && (r_p == w_last_rhs);
                    r_state  <= S_OUT_EM;
                end
                S_OUT_EM: begin
                    if (r_last) begin
                        r_busy  <= 1'b0;
                        r_load  <= '0;
                        r_fault <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        if (r_p == w_last_rhs) begin
                            r_p   <= '0;
                            r_src <= r_src + RW'(1);
                        end else begin
                            r_p <= r_p + CW'(1);
                        end
                        r_state <= S_OUT_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.wr_sel = gjs_pkg::WR_COPY;
        o_st_addr    = r_k;
        o_wk_addr_a  = f_addr(r_src, r_p);
        o_wk_addr_b  = f_addr(r_dst, r_p);
        o_wk_waddr   = f_addr(r_dst, r_p);
        unique case (r_state)
            S_IDLE: begin
                o_st_addr      = AW'(r_load);
                o_cmd.store_we = i_start && (r_load < w_total);
            end
            S_COPY_WR: begin
                o_cmd.work_we = 1'b1;
                o_wk_waddr    = r_k;
            end
            S_PV_RD: begin
                o_wk_addr_a = f_addr(r_src, CW'(r_src));
                o_wk_addr_b = f_addr(r_dst, CW'(r_src));
            end
            S_PV_LAT: begin
                o_cmd.lat_den    = 1'b1;
                o_cmd.lat_num    = 1'b1;
                o_cmd.num_from_b = 1'b1;
            end
            S_PV_CHK: o_cmd.div_go  = !i_stat.den_zero;
            S_RO_DIV: o_cmd.lat_mul = i_stat.div_done;
            S_MA_MUL: o_cmd.mul_go  = 1'b1;
            S_MA_WR: begin
                o_cmd.work_we = 1'b1;
                o_cmd.wr_sel  = (r_p == CW'(r_src)) ? gjs_pkg::WR_ZERO
                                                     : gjs_pkg::WR_UPDATE;
            end
            S_NM_RD:  o_wk_addr_a   = f_addr(r_src, CW'(r_src));
            S_NM_LAT: o_cmd.lat_den = 1'b1;
            S_ND_LAT: o_cmd.lat_num = 1'b1;
            S_ND_GO:  o_cmd.div_go  = 1'b1;
            S_ND_WAIT: begin
                o_cmd.work_we = i_stat.div_done;
                o_cmd.wr_sel  = gjs_pkg::WR_QUOT;
                o_wk_waddr    = f_addr(r_src, r_p);
            end
            S_OUT_RD: o_wk_addr_a = f_addr(r_src, CW'(i_n) + r_p);
            default: begin
            end
        endcase
    end

    assign o_busy     = r_busy;
    assign o_strobe   = r_strobe;
    assign o_row      = r_row;
    assign o_col      = r_col;
    assign o_last     = r_last;
    assign o_singular = r_fault;

endmodule

>>> rtl/core/gauss_jordan_solver_core.sv
// ----------------------------------------------------------------------------
// gauss_jordan_solver_core
// Solves A * X = B by Gauss-Jordan elimination without pivoting in signed
// fixed point, fed one augmented-matrix element per request.
// ----------------------------------------------------------------------------
// Write size_n and rhs_count first (values of 0 count as 1, values above the
// maximum are clamped). Then send the augmented matrix [A|B] row-major, one
// element per request, accepted at each clock edge with start high and busy
// low; elements beyond size_n*(size_n+rhs_count) are dropped. The request
// that carries last_element raises busy and starts the solve: the elements
// are copied into a work memory, every row update costs one pivot division
// plus a read, a multiply and a write per element of the row, and
// normalisation divides each element of a row by its diagonal. The shared
// restoring divider sets the pace. The solution then leaves row-major, each
// result shown for exactly one cycle with o_strobe high; the receiver cannot
// stall, so capture it then. A zero pivot ends the solve at once and every
// result carries o_singular with a value of zero. busy falls after the
// result marked last; write configuration only while idle.
// ----------------------------------------------------------------------------
module gauss_jordan_solver_core #(
    parameter int unsigned MAX_N     = 8,
    parameter int unsigned MAX_RHS   = 8,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // element requests
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [gjs_pkg::DATA_W-1:0]    i_element_value,
    input  logic                                 i_last_element,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gjs_pkg::IDX_W-1:0]            i_cfg_index,
    input  logic [gjs_pkg::REG_W-1:0]            i_cfg_data,
    // solution results
    output logic                                 o_strobe,
    output logic signed [gjs_pkg::DATA_W-1:0]    o_solution_value,
    output logic [gjs_pkg::OUT_W-1:0]            o_solution_row,
    output logic [gjs_pkg::OUT_W-1:0]            o_solution_column,
    output logic                                 o_singular,
    output logic                                 o_last_result
);

    localparam int unsigned WMAX  = MAX_N + MAX_RHS;
    localparam int unsigned DEPTH = MAX_N * WMAX;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned RW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int unsigned CW    = $clog2(WMAX);
    localparam int unsigned NBW   = $clog2(MAX_N + 1);
    localparam int unsigned MBW   = $clog2(MAX_RHS + 1);

    logic [gjs_pkg::REG_W-1:0] r_size_n;
    logic [gjs_pkg::REG_W-1:0] r_rhs_count;

    logic [NBW-1:0]            w_n;
    logic [MBW-1:0]            w_m;
    gjs_pkg::t_dp_cmd          w_cmd;
    gjs_pkg::t_dp_stat         w_stat;
    logic [AW-1:0]             w_st_addr;
    logic [AW-1:0]             w_wk_addr_a;
    logic [AW-1:0]             w_wk_addr_b;
    logic [AW-1:0]             w_wk_waddr;
    logic signed [31:0]        w_rd_value;
    logic [RW-1:0]             w_row;
    logic [CW-1:0]             w_col;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_n    <= gjs_pkg::REG_W'(1);
            r_rhs_count <= gjs_pkg::REG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gjs_pkg::REG_SIZE_N:    r_size_n    <= i_cfg_data;
                gjs_pkg::REG_RHS_COUNT: r_rhs_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // clamp the sizes into 1..MAX
    always_comb begin
        if (r_size_n == '0) begin
            w_n = NBW'(1);
        end else if (r_size_n > MAX_N) begin
            w_n = NBW'(MAX_N);
        end else begin
            w_n = NBW'(r_size_n);
        end
        if (r_rhs_count == '0) begin
            w_m = MBW'(1);
        end else if (r_rhs_count > MAX_RHS) begin
            w_m = MBW'(MAX_RHS);
        end else begin
            w_m = MBW'(r_rhs_count);
        end
    end

    gjs_ctrl #(
        .MAX_N   (MAX_N),
        .MAX_RHS (MAX_RHS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last      (i_last_element),
        .i_n         (w_n),
        .i_m         (w_m),
        .o_busy      (busy),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat),
        .o_st_addr   (w_st_addr),
        .o_wk_addr_a (w_wk_addr_a),
        .o_wk_addr_b (w_wk_addr_b),
        .o_wk_waddr  (w_wk_waddr),
        .o_strobe    (o_strobe),
        .o_row       (w_row),
        .o_col       (w_col),
        .o_last      (o_last_result),
        .o_singular  (o_singular)
    );

    gjs_dp #(
        .MAX_N     (MAX_N),
        .MAX_RHS   (MAX_RHS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_st_addr    (w_st_addr),
        .i_load_value (i_element_value),
        .i_wk_addr_a  (w_wk_addr_a),
        .i_wk_addr_b  (w_wk_addr_b),
        .i_wk_waddr   (w_wk_waddr),
        .o_rd_value   (w_rd_value)
    );

    // drop the value of a singular system to zero
    assign o_solution_value  = o_singular ? '0 : w_rd_value;
    assign o_solution_row    = gjs_pkg::OUT_W'(w_row);
    assign o_solution_column = gjs_pkg::OUT_W'(w_col);

endmodule

>>> rtl/core/gjs_checker.sv
// ----------------------------------------------------------------------------
// gjs_checker
// Port-level checks of the solver: result strobes, singular results and
// the busy window.
// ----------------------------------------------------------------------------
module gjs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               i_last_element,
    input logic                               o_strobe,
    input logic signed [gjs_pkg::DATA_W-1:0]  o_solution_value,
    input logic                               o_singular,
    input logic                               o_last_result
);

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a solve");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_singular) |-> (o_solution_value == '0))
        else $error("singular result with a non-zero value");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_result) |=> !busy)
        else $error("busy held after the final result");

    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_last_element))
        else $error("busy rose without a last element");

    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results on adjacent cycles");

endmodule

bind gauss_jordan_solver_core gjs_checker u_gjs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_last_element   (i_last_element),
    .o_strobe         (o_strobe),
    .o_solution_value (o_solution_value),
    .o_singular       (o_singular),
    .o_last_result    (o_last_result)
);
